>>> design/byte_pattern_replace_stream_core_assert.svh
// Assertion macros shared by the checker of the byte pattern replace stream core.
`ifndef BYTE_PATTERN_REPLACE_STREAM_CORE_ASSERT_SVH
`define BYTE_PATTERN_REPLACE_STREAM_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define BPRS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define BPRS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Same-cycle implication that also holds while reset is applied.
`define BPRS_ASSERT_ALWAYS(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error(msg);

`endif

>>> design/bprs_pkg.sv
// Shared constants, types and helpers of the byte pattern replace stream core.
package bprs_pkg;

  localparam int unsigned ByteW      = 8;
  localparam int unsigned Lanes      = 8;
  localparam int unsigned LaneIdxW   = $clog2(Lanes);
  localparam int unsigned CountW     = $clog2(Lanes + 1);
  localparam int unsigned DataW      = Lanes * ByteW;
  localparam int unsigned CfgDataW   = 64;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned PosW       = 32;
  localparam int unsigned LimitW     = 31;
  localparam int unsigned LenW       = 4;
  localparam int unsigned QueueDepth = 4;

  localparam logic [LimitW-1:0] LimitDefault = 31'h7FFF_FFFF;

  typedef enum logic [CfgIdxW-1:0] {
    RegPatternBytes     = 3'd0,
    RegPatternLength    = 3'd1,
    RegReplacementBytes = 3'd2,
    RegReplacementLen   = 3'd3,
    RegStartOffset      = 3'd4,
    RegReplacementLimit = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [DataW-1:0]  data;
    logic [CountW-1:0] count;
    logic              last;
  } cmd_t;

  function automatic logic [LenW-1:0] clamp_len(logic [LenW-1:0] v);
    return (v > LenW'(Lanes)) ? LenW'(Lanes) : v;
  endfunction

endpackage

>>> design/bprs_fifo.sv
// Command queue between the classifying front end and the emitting back end.
module bprs_fifo import bprs_pkg::*; #(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  input  logic pop_i,
  output cmd_t cmd_o,
  output logic full_o,
  output logic empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign cmd_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

>>> design/bprs_front.sv
// Front end: configuration registers, match window and per-transfer command build.
module bprs_front import bprs_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  input  logic [ByteW-1:0]    in_byte_i,
  input  logic                end_in_i,
  output logic                in_stall_o,
  input  logic                q_full_i,
  output logic                q_push_o,
  output cmd_t                q_cmd_o
);

  logic [DataW-1:0]    pat_q;
  logic [LenW-1:0]     pat_len_q;
  logic [DataW-1:0]    repl_q;
  logic [LenW-1:0]     repl_len_q;
  logic [PosW-1:0]     start_q;
  logic [LimitW-1:0]   limit_q;

  logic [DataW-1:0]    win_q, win_d;
  logic [LaneIdxW-1:0] fill_q, fill_d;
  logic [PosW-1:0]     pos_q, pos_d;
  logic [LimitW-1:0]   left_q, left_d;
  logic [LenW-1:0]     alen_q, alen_d;

  logic                accept;
  logic                first;
  logic [LenW-1:0]     alen;
  logic [LenW-1:0]     alen_m1;
  logic [LimitW-1:0]   left;
  logic                searching;
  logic [DataW-1:0]    win_ins;
  logic [CountW-1:0]   nfill;
  logic                full_win;
  logic                match;
  cmd_t                cmd;

  assign accept     = in_valid_i && !q_full_i;
  assign in_stall_o = q_full_i;
  assign q_push_o   = accept;
  assign q_cmd_o    = cmd;

  assign first     = (pos_q == '0);
  assign alen      = first ? clamp_len(pat_len_q) : alen_q;
  assign alen_m1   = alen - LenW'(1);
  assign left      = first ? limit_q : left_q;
  assign searching = (alen != '0) && (left != '0) && (pos_q >= start_q);
  assign nfill     = CountW'(fill_q) + CountW'(1);
  assign full_win  = (nfill == CountW'(alen));

  always_comb begin
    for (int i = 0; i < Lanes; i++) begin
      win_ins[i*ByteW +: ByteW] = (LaneIdxW'(i) == fill_q) ? in_byte_i
                                                            : win_q[i*ByteW +: ByteW];
    end
  end

  always_comb begin
    match = 1'b1;
    for (int i = 0; i < Lanes; i++) begin
      if ((LenW'(i) < alen) && (win_ins[i*ByteW +: ByteW] != pat_q[i*ByteW +: ByteW])) begin
        match = 1'b0;
      end
    end
  end

  always_comb begin
    cmd.data  = win_ins;
    cmd.count = nfill;
    cmd.last  = end_in_i;
    win_d     = win_ins;
    fill_d    = fill_q;
    left_d    = left;
    alen_d    = alen;
    pos_d     = (pos_q == '1) ? pos_q : pos_q + PosW'(1);
    if (!searching) begin
      fill_d = '0;
    end else if (!full_win) begin
      fill_d = nfill[LaneIdxW-1:0];
      if (!end_in_i) begin
        cmd.count = '0;
      end
    end else if (match) begin
      cmd.data  = repl_q;
      cmd.count = CountW'(clamp_len(repl_len_q));
      fill_d    = '0;
      left_d    = left - LimitW'(1);
    end else begin
      if (!end_in_i) begin
        cmd.count = CountW'(1);
      end
      win_d  = win_ins >> ByteW;
      fill_d = alen_m1[LaneIdxW-1:0];
    end
    if (end_in_i) begin
      fill_d = '0;
      pos_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_q      <= '0;
      pat_len_q  <= '0;
      repl_q     <= '0;
      repl_len_q <= '0;
      start_q    <= '0;
      limit_q    <= LimitDefault;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        RegPatternBytes:     pat_q      <= cfg_wdata_i[DataW-1:0];
        RegPatternLength:    pat_len_q  <= cfg_wdata_i[LenW-1:0];
        RegReplacementBytes: repl_q     <= cfg_wdata_i[DataW-1:0];
        RegReplacementLen:   repl_len_q <= cfg_wdata_i[LenW-1:0];
        RegStartOffset:      start_q    <= cfg_wdata_i[PosW-1:0];
        RegReplacementLimit: limit_q    <= cfg_wdata_i[LimitW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      pos_q  <= '0;
      left_q <= '0;
      alen_q <= '0;
    end else if (accept) begin
      fill_q <= fill_d;
      pos_q  <= pos_d;
      left_q <= left_d;
      alen_q <= alen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      win_q <= win_d;
    end
  end

endmodule

>>> design/bprs_back.sv
// Back end: takes commands from the queue and emits their bytes one per transfer.
module bprs_back import bprs_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_empty_i,
  input  cmd_t             q_cmd_i,
  output logic             q_pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [ByteW-1:0] out_byte_o,
  output logic             has_byte_o,
  output logic             end_out_o
);

  cmd_t cur_q;
  logic cur_valid_q;
  logic xfer;
  logic done;
  logic free;
  logic keep;

  assign xfer    = cur_valid_q && !out_stall_i;
  assign done    = xfer && (cur_q.count <= CountW'(1));
  assign free    = !cur_valid_q || done;
  assign q_pop_o = free && !q_empty_i;
  assign keep    = (q_cmd_i.count != '0) || q_cmd_i.last;

  assign out_valid_o = cur_valid_q;
  assign has_byte_o  = (cur_q.count != '0);
  assign out_byte_o  = has_byte_o ? cur_q.data[ByteW-1:0] : '0;
  assign end_out_o   = cur_q.last && (cur_q.count <= CountW'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
    end else if (free) begin
      cur_valid_q <= q_pop_o && keep;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      cur_q <= q_cmd_i;
    end else if (xfer) begin
      cur_q.data  <= cur_q.data >> ByteW;
      cur_q.count <= cur_q.count - CountW'(1);
    end
  end

endmodule

>>> design/byte_pattern_replace_stream_core.sv
// Byte stream find-and-replace core: front end, command queue and back end.
//
// Input channel: one source byte per transfer (in_valid_i high, in_stall_o low),
// end_in_i marks the last byte of a stream. Output channel: one result per
// transfer (out_valid_o high, out_stall_i low) with out_byte_o, has_byte_o and
// end_out_o; a stream ends with end_out_o on its last result, or on a bare
// marker (has_byte_o low, out_byte_o zero) when nothing is left to emit.
// Configuration: cfg_we_i writes cfg_wdata_i into register cfg_idx_i; the user
// must write only while the core is idle, which the block does not enforce.
// Throughput: one source byte per cycle while the command queue has room;
// an item that yields bytes holds the back end while they go out, one byte per
// cycle while out_stall_i is low; one that yields nothing takes one queue slot.
// An item's first result goes into the command queue, then is loaded from it
// into the back end register, from which it is offered.
// Reset: clears stream position, window fill and queue, loads the register
// defaults; no clearing pass is needed. While the receiver stalls, the
// result on offer holds and the front end keeps taking bytes until the
// queue of QueueDepth commands fills, then raises in_stall_o.
module byte_pattern_replace_stream_core import bprs_pkg::*; #(
  parameter int unsigned QueueDepth = bprs_pkg::QueueDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [ByteW-1:0]    in_byte_i,
  input  logic                end_in_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [ByteW-1:0]    out_byte_o,
  output logic                has_byte_o,
  output logic                end_out_o
);

  cmd_t push_cmd;
  cmd_t pop_cmd;
  logic push;
  logic pop;
  logic q_full;
  logic q_empty;

  bprs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_byte_i   (in_byte_i),
    .end_in_i    (end_in_i),
    .in_stall_o  (in_stall_o),
    .q_full_i    (q_full),
    .q_push_o    (push),
    .q_cmd_o     (push_cmd)
  );

  bprs_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .pop_i   (pop),
    .cmd_o   (pop_cmd),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  bprs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_cmd_i     (pop_cmd),
    .q_pop_o     (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .has_byte_o  (has_byte_o),
    .end_out_o   (end_out_o)
  );

endmodule

>>> design/bprs_checker.sv
// Port-level assertion checker for the byte pattern replace stream core, with its bind.
`include "byte_pattern_replace_stream_core_assert.svh"

module bprs_checker import bprs_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input logic [ByteW-1:0]    out_byte_o,
  input logic                has_byte_o,
  input logic                end_out_o
);

  `BPRS_ASSERT_NEXT(a_out_valid_held, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o, "result withdrawn while stalled")
  `BPRS_ASSERT_NEXT(a_out_payload_held, clk_i, rst_ni, out_valid_o && out_stall_i, $stable(out_byte_o) && $stable(has_byte_o) && $stable(end_out_o), "stalled result changed")
  `BPRS_ASSERT_NOW(a_bare_marker_ends, clk_i, rst_ni, out_valid_o && !has_byte_o, end_out_o && (out_byte_o == '0), "bare marker without end flag or with a byte")
  `BPRS_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni && $past(!rst_ni), !out_valid_o && !in_stall_o, "outputs active during reset")

endmodule

bind byte_pattern_replace_stream_core bprs_checker u_checker (.*);

>>> tb/byte_pattern_replace_stream_checker.sv
// Checker for the byte pattern replace stream core: predicts each rewritten stream and compares.
`timescale 1ns / 1ps

module byte_pattern_replace_stream_checker import bprs_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  logic [ByteW-1:0]    in_byte_i,
  input  logic                end_in_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  logic [ByteW-1:0]    out_byte_i,
  input  logic                has_byte_i,
  input  logic                end_out_i,
  output int unsigned         fail_count_o,
  output int unsigned         pending_o
);

  localparam int unsigned MaxResults = 9;
  localparam int unsigned MaxReports = 10;

  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             has_byte;
    logic             end_flag;
  } result_t;

  logic [CfgDataW-1:0] pat_bytes;
  logic [LenW-1:0]     pat_len;
  logic [CfgDataW-1:0] rep_bytes;
  logic [LenW-1:0]     rep_len;
  logic [PosW-1:0]     search_from;
  logic [LimitW-1:0]   repl_limit;

  logic [ByteW-1:0]    win [Lanes];
  int unsigned         win_fill;
  logic [PosW-1:0]     pos_count;
  logic [LimitW-1:0]   repl_left;
  int unsigned         act_len;

  result_t             step_q[$];
  result_t             expected_q[$];
  result_t             want;
  result_t             got;
  int unsigned         mismatches = 0;
  int unsigned         backlog = 0;

  assign fail_count_o = mismatches;
  assign pending_o    = backlog;

  function automatic int unsigned cap_len(logic [LenW-1:0] v);
    return (v > LenW'(Lanes)) ? Lanes : int'(v);
  endfunction

  task automatic push_result(input logic [ByteW-1:0] b);
    if (step_q.size() < MaxResults) step_q.push_back('{b, 1'b1, 1'b0});
  endtask

  task automatic spill_window();
    int unsigned i;
    for (i = 0; i < win_fill; i++) push_result(win[i]);
    win_fill = 0;
  endtask

  task automatic shift_window(input int unsigned k);
    int unsigned i;
    if (k > win_fill) k = win_fill;
    for (i = 0; i + k < win_fill; i++) win[i] = win[i + k];
    win_fill -= k;
  endtask

  task automatic rewrite_byte(input logic [ByteW-1:0] b, input logic last);
    int unsigned i;
    int unsigned rl;
    bit          hit;
    bit          searching;
    step_q.delete();
    if (pos_count == '0) begin
      act_len   = cap_len(pat_len);
      repl_left = repl_limit;
    end
    searching = (act_len > 0) && (repl_left != '0) && (pos_count >= search_from);
    if (!searching) begin
      spill_window();
      push_result(b);
    end else begin
      if (win_fill >= Lanes) begin
        push_result(win[0]);
        shift_window(1);
      end
      win[win_fill] = b;
      win_fill++;
      while (win_fill > 0 && win_fill >= act_len) begin
        hit = 1'b1;
        for (i = 0; i < act_len; i++) begin
          if (win[i] != pat_bytes[8*i +: 8]) hit = 1'b0;
        end
        if (hit) begin
          rl = cap_len(rep_len);
          for (i = 0; i < rl; i++) push_result(rep_bytes[8*i +: 8]);
          shift_window(act_len);
          repl_left--;
          if (repl_left == '0) spill_window();
        end else begin
          push_result(win[0]);
          shift_window(1);
        end
      end
    end
    if (pos_count != '1) pos_count++;
    if (last) begin
      spill_window();
      if (step_q.size() == 0) begin
        step_q.push_back('{'0, 1'b0, 1'b1});
      end else begin
        step_q[step_q.size() - 1].end_flag = 1'b1;
      end
      pos_count = '0;
      win_fill  = 0;
    end
    foreach (step_q[k]) expected_q.push_back(step_q[k]);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_bytes   = '0;
      pat_len     = '0;
      rep_bytes   = '0;
      rep_len     = '0;
      search_from = '0;
      repl_limit  = LimitDefault;
      win_fill    = 0;
      pos_count   = '0;
      repl_left   = '0;
      act_len     = 0;
      expected_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegPatternBytes:     pat_bytes   = cfg_wdata_i;
          RegPatternLength:    pat_len     = cfg_wdata_i[LenW-1:0];
          RegReplacementBytes: rep_bytes   = cfg_wdata_i;
          RegReplacementLen:   rep_len     = cfg_wdata_i[LenW-1:0];
          RegStartOffset:      search_from = cfg_wdata_i[PosW-1:0];
          RegReplacementLimit: repl_limit  = cfg_wdata_i[LimitW-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) rewrite_byte(in_byte_i, end_in_i);
      if (out_valid_i && !out_stall_i) begin
        got = '{out_byte_i, has_byte_i, end_out_i};
        if (expected_q.size() == 0) begin
          if (mismatches < MaxReports) begin
            $display("%0t: unexpected transfer: byte %02h has_byte %0b end %0b",
                     $time, got.data, got.has_byte, got.end_flag);
          end
          mismatches++;
        end else begin
          want = expected_q.pop_front();
          if (got.data !== want.data || got.has_byte !== want.has_byte ||
              got.end_flag !== want.end_flag) begin
            if (mismatches < MaxReports) begin
              $display("%0t: mismatch: expected %02h/%0b/%0b got %02h/%0b/%0b (byte/has/end)",
                       $time, want.data, want.has_byte, want.end_flag,
                       got.data, got.has_byte, got.end_flag);
            end
            mismatches++;
          end
        end
      end
    end
    backlog = expected_q.size();
  end

endmodule

>>> tb/byte_pattern_replace_stream_core_tb.sv
// Testbench top: drives configuration, source streams and output back-pressure of the core.
`timescale 1ns / 1ps

module byte_pattern_replace_stream_core_tb import bprs_pkg::*; ();

  localparam int ClkPeriod  = 10;
  localparam int IdlePct    = 15;
  localparam int ItemTarget = 370;
  localparam int HoldCycles = 300;
  localparam int DrainCycles = 8;
  localparam int TailCycles = 10;
  localparam int CycleLimit = 200000;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  cfg_reg_e            cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [ByteW-1:0]    in_byte_i;
  logic                end_in_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [ByteW-1:0]    out_byte_o;
  logic                has_byte_o;
  logic                end_out_o;

  int unsigned         fail_count;
  int unsigned         pending;
  int                  cycle_count = 0;
  int                  items_sent = 0;
  int                  tx_idle_pct = IdlePct;
  int                  rx_idle_pct = IdlePct;
  logic                hold_req = 1'b0;
  int                  hold_left = HoldCycles;

  logic [ByteW-1:0]    stream_q[$];
  logic [CfgDataW-1:0] cur_pat;
  logic [LenW-1:0]     cur_pat_len;
  logic [ByteW-1:0]    alpha_a;
  logic [ByteW-1:0]    alpha_b;

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  byte_pattern_replace_stream_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_byte_i   (in_byte_i),
    .end_in_i    (end_in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .has_byte_o  (has_byte_o),
    .end_out_o   (end_out_o)
  );

  byte_pattern_replace_stream_checker rewrite_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .in_byte_i    (in_byte_i),
    .end_in_i     (end_in_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_byte_i   (out_byte_o),
    .has_byte_i   (has_byte_o),
    .end_out_i    (end_out_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req && hold_left != 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= ($urandom_range(99) < rx_idle_pct);
      end
    end
  end

  task automatic apply_setting(input logic [CfgDataW-1:0] pat, input logic [LenW-1:0] pat_len,
                               input logic [CfgDataW-1:0] rep, input logic [LenW-1:0] rep_len,
                               input logic [PosW-1:0] offset, input logic [LimitW-1:0] limit);
    cur_pat     = pat;
    cur_pat_len = pat_len;
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= RegPatternBytes;
    cfg_wdata_i <= pat;
    @(posedge clk_i);
    cfg_idx_i   <= RegPatternLength;
    cfg_wdata_i <= CfgDataW'(pat_len);
    @(posedge clk_i);
    cfg_idx_i   <= RegReplacementBytes;
    cfg_wdata_i <= rep;
    @(posedge clk_i);
    cfg_idx_i   <= RegReplacementLen;
    cfg_wdata_i <= CfgDataW'(rep_len);
    @(posedge clk_i);
    cfg_idx_i   <= RegStartOffset;
    cfg_wdata_i <= CfgDataW'(offset);
    @(posedge clk_i);
    cfg_idx_i   <= RegReplacementLimit;
    cfg_wdata_i <= CfgDataW'(limit);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic pick_setting();
    logic [CfgDataW-1:0] pat;
    logic [LenW-1:0]     plen;
    logic [PosW-1:0]     offset;
    logic [LimitW-1:0]   limit;
    int                  j;
    int                  r;
    alpha_a = ByteW'($urandom);
    alpha_b = ByteW'($urandom);
    for (j = 0; j < Lanes; j++) pat[8*j +: 8] = $urandom_range(0, 1) ? alpha_a : alpha_b;
    if ($urandom_range(0, 7) == 0) pat = {$urandom, $urandom};
    r = $urandom_range(0, 11);
    plen = (r == 0) ? '0 : (r >= 9) ? LenW'($urandom_range(9, 15)) : LenW'(r);
    r = $urandom_range(0, 9);
    offset = (r < 6) ? '0 : (r < 9) ? PosW'($urandom_range(1, 12)) : PosW'($urandom);
    r = $urandom_range(0, 19);
    limit = (r < 10) ? LimitDefault : (r < 17) ? LimitW'($urandom_range(0, 3)) : LimitW'($urandom);
    apply_setting(pat, plen, {$urandom, $urandom}, LenW'($urandom_range(0, 15)), offset, limit);
  endtask

  task automatic play_stream(input bit close);
    int k;
    for (k = 0; k < stream_q.size(); k++) begin
      while ($urandom_range(99) < tx_idle_pct) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
      in_valid_i <= 1'b1;
      in_byte_i  <= stream_q[k];
      end_in_i   <= close && (k == stream_q.size() - 1);
      do @(negedge clk_i); while (in_stall_o);
      @(posedge clk_i);
      items_sent++;
    end
  endtask

  task automatic play_packed(input logic [CfgDataW-1:0] packed_v, input int count, input bit close);
    int j;
    stream_q.delete();
    for (j = 0; j < count; j++) stream_q.push_back(packed_v[8*j +: 8]);
    play_stream(close);
  endtask

  // mostly pattern runs and near misses over a two-letter alphabet, some pure noise
  task automatic build_stream();
    int  want_len;
    int  plen;
    int  cut;
    int  mode;
    int  j;
    bit  noise;
    stream_q.delete();
    plen     = (cur_pat_len > LenW'(Lanes)) ? Lanes : int'(cur_pat_len);
    want_len = $urandom_range(1, 20);
    noise    = ($urandom_range(0, 5) == 0);
    while (stream_q.size() < want_len) begin
      mode = $urandom_range(0, 5);
      if (!noise && plen > 0 && mode == 0) begin
        for (j = 0; j < plen; j++) stream_q.push_back(cur_pat[8*j +: 8]);
      end else if (!noise && plen > 1 && mode == 1) begin
        cut = $urandom_range(1, plen - 1);
        for (j = 0; j < cut; j++) stream_q.push_back(cur_pat[8*j +: 8]);
      end else if (noise || mode == 2) begin
        stream_q.push_back(ByteW'($urandom));
      end else begin
        stream_q.push_back($urandom_range(0, 1) ? alpha_a : alpha_b);
      end
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  initial begin
    int phase;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = RegPatternBytes;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    in_byte_i   = '0;
    end_in_i    = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    apply_setting('0, 4'd0, '0, 4'd0, '0, LimitDefault);
    play_packed(64'hFF00, 2, 1'b1);
    wait_drained();
    apply_setting(64'h6261, 4'd2, 64'h5A5958, 4'd3, '0, LimitDefault);
    play_packed(64'h62_61_62_61_78, 5, 1'b1);
    wait_drained();
    apply_setting({8{8'hFF}}, 4'd15, '0, 4'd15, '0, LimitDefault);
    play_packed({8{8'hFF}}, 8, 1'b1);
    wait_drained();
    apply_setting(64'h61, 4'd1, '0, 4'd0, '0, LimitDefault);
    play_packed(64'h61, 1, 1'b1);
    wait_drained();
    // raise the offset while bytes are held, then close the stream
    apply_setting(64'h636261, 4'd3, 64'h51, 4'd1, '0, LimitDefault);
    play_packed(64'h6261, 2, 1'b0);
    wait_drained();
    apply_setting(64'h62, 4'd1, 64'h51, 4'd1, 32'hFFFF_FFFF, LimitDefault);
    play_packed(64'h63, 1, 1'b1);
    wait_drained();
    // swap pattern bytes mid-stream; the new length waits for the next stream
    apply_setting(64'h6261, 4'd2, 64'h51, 4'd1, '0, LimitDefault);
    play_packed(64'h63, 1, 1'b0);
    wait_drained();
    apply_setting(64'h6463, 4'd1, 64'h51, 4'd1, '0, LimitDefault);
    play_packed(64'h64, 1, 1'b1);
    wait_drained();
    apply_setting(64'h61, 4'd1, 64'h5A5A, 4'd2, 32'd1, 31'd1);
    play_packed(64'h616161, 3, 1'b1);
    wait_drained();
    apply_setting(64'h61, 4'd1, 64'h5A, 4'd1, '0, '0);
    play_packed(64'h61, 1, 1'b1);
    wait_drained();

    phase = 0;
    while (items_sent < ItemTarget) begin
      if (phase == 1) hold_req <= 1'b1;
      if (phase == 2) begin
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
      end
      if (phase == 4) begin
        tx_idle_pct = IdlePct;
        rx_idle_pct <= IdlePct;
      end
      pick_setting();
      if ($urandom_range(0, 3) == 0) begin
        build_stream();
        play_stream(1'b0);
        wait_drained();
        pick_setting();
      end
      repeat ($urandom_range(2, 5)) begin
        build_stream();
        play_stream(1'b1);
      end
      wait_drained();
      phase++;
    end

    repeat (TailCycles) @(posedge clk_i);
    @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
